/* rtl/core/strict_priority_multi_fifo_unit_defines.svh */
// Assertion helpers shared by the checking code of the priority queue.
// Each macro expects a clock named clk and an active-low reset named arst_n.
`ifndef STRICT_PRIORITY_MULTI_FIFO_UNIT_DEFINES_SVH
`define STRICT_PRIORITY_MULTI_FIFO_UNIT_DEFINES_SVH

// Same-cycle implication.
`define SPMF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SPMF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/spmf_pkg.sv */
`default_nettype none

package spmf_pkg;

	// Request kinds.
	localparam logic REQ_ENQ = 1'b0;
	localparam logic REQ_DEQ = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_LEVEL = 2'd1,
		ST_FULL      = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	// Outcome of one request, as handed from the queue control to the result stage.
	typedef struct packed {
		status_t    status;
		logic [3:0] level;
		logic       rd;
	} res_info_t;

endpackage

`default_nettype wire

/* rtl/core/spmf_req_if.sv */
`default_nettype none

interface spmf_req_if;
	logic               valid;
	logic               ready;
	logic               req_type;
	logic signed [31:0] value;
	logic [3:0]         priority_req;

	modport source (output valid, output req_type, output value, output priority_req,
		input ready);
	modport sink (input valid, input req_type, input value, input priority_req,
		output ready);
endinterface

`default_nettype wire

/* rtl/core/spmf_rsp_if.sv */
`default_nettype none

interface spmf_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] data_out;
	logic [1:0]         status;
	logic [3:0]         served_level;

	modport source (output valid, output data_out, output status, output served_level,
		input ready);
	modport sink (input valid, input data_out, input status, input served_level,
		output ready);
endinterface

`default_nettype wire

/* rtl/core/spmf_ram.sv */
`default_nettype none

module spmf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/core/spmf_ctrl.sv */
`default_nettype none

module spmf_ctrl #(
	parameter int LEVELS = 8,
	parameter int DEPTH  = 128,
	parameter int AW     = 10
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire logic               req_type,
	input  wire logic signed [31:0] value,
	input  wire logic [3:0]         priority_req,
	output logic                    ram_we,
	output logic [AW-1:0]           ram_waddr,
	output logic [31:0]             ram_wdata,
	output logic                    ram_re,
	output logic [AW-1:0]           ram_raddr,
	output spmf_pkg::res_info_t     info
);

	import spmf_pkg::*;

	localparam int LW = $clog2(LEVELS);
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [PW-1:0] head_q  [LEVELS];
	logic [PW-1:0] tail_q  [LEVELS];
	logic [CW-1:0] count_q [LEVELS];

	logic          lvl_valid;
	logic [LW-1:0] enq_lvl;
	logic          enq_full;
	logic          enq_ok;
	logic          deq_found;
	logic [LW-1:0] deq_lvl;
	logic          deq_ok;

	// Enqueue checks: level range, then occupancy of the addressed level.
	assign lvl_valid = (int'(priority_req) < LEVELS);
	assign enq_lvl   = priority_req[LW-1:0];
	assign enq_full  = (count_q[enq_lvl] == CW'(DEPTH));
	assign enq_ok    = (req_type == REQ_ENQ) && lvl_valid && !enq_full;

	// Priority encoder: the lowest-numbered level that holds an entry.
	always_comb begin
		deq_found = 1'b0;
		deq_lvl   = '0;
		for (int i = LEVELS - 1; i >= 0; i--) begin
			if (count_q[i] != '0) begin
				deq_found = 1'b1;
				deq_lvl   = LW'(i);
			end
		end
	end

	assign deq_ok = (req_type == REQ_DEQ) && deq_found;

	// Storage commands: each level owns a contiguous block of DEPTH words.
	assign ram_we    = accept && enq_ok;
	assign ram_waddr = AW'(enq_lvl) * AW'(DEPTH) + AW'(tail_q[enq_lvl]);
	assign ram_wdata = value;
	assign ram_re    = accept && deq_ok;
	assign ram_raddr = AW'(deq_lvl) * AW'(DEPTH) + AW'(head_q[deq_lvl]);

	// Outcome of the request.
	always_comb begin
		info.rd = 1'b0;
		if (req_type == REQ_ENQ) begin
			if (!lvl_valid) begin
				info.status = ST_BAD_LEVEL;
				info.level  = '0;
			end else if (enq_full) begin
				info.status = ST_FULL;
				info.level  = '0;
			end else begin
				info.status = ST_OK;
				info.level  = 4'(enq_lvl);
			end
		end else begin
			if (deq_found) begin
				info.status = ST_OK;
				info.level  = 4'(deq_lvl);
				info.rd     = 1'b1;
			end else begin
				info.status = ST_EMPTY;
				info.level  = '0;
			end
		end
	end

	// Pointer and occupancy update; a beat touches at most one level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else if (accept) begin
			for (int i = 0; i < LEVELS; i++) begin
				if (enq_ok && (enq_lvl == LW'(i))) begin
					tail_q[i]  <= (tail_q[i] == PW'(DEPTH - 1)) ? '0 : tail_q[i] + 1'b1;
					count_q[i] <= count_q[i] + 1'b1;
				end
				if (deq_ok && (deq_lvl == LW'(i))) begin
					head_q[i]  <= (head_q[i] == PW'(DEPTH - 1)) ? '0 : head_q[i] + 1'b1;
					count_q[i] <= count_q[i] - 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/core/strict_priority_multi_fifo_unit.sv */
// Strict-priority queue of LEVELS circular FIFOs, each DEPTH words deep.
// The req channel carries one request per beat: an enqueue (value at level
// priority_req) or a dequeue (head of the lowest-numbered non-empty level).
// The rsp channel returns exactly one result beat per request, in order:
// data_out, status (ok, bad level, level full, all empty) and served_level.
// A result passes the registered read of the entry storage and then the
// output register before it is offered.
// Throughput: one request per cycle unless the receiver stalls. The level
// counts and pointers sit in flip-flops and a priority encoder picks the
// level in the cycle of the beat, so back-to-back requests see the effect
// of each other at once.
// Reset empties every level; no clearing pass is needed since only written
// entries are ever read. Reset also drops any result in flight.
// When the receiver stalls, the output register holds its beat and one more
// result waits in the read stage; req.ready then falls until the output
// register drains, so no request is accepted without room for its result.
`default_nettype none

`include "strict_priority_multi_fifo_unit_defines.svh"

module strict_priority_multi_fifo_unit #(
	parameter int LEVELS = 8,
	parameter int DEPTH  = 128
) (
	input  wire logic clk,
	input  wire logic arst_n,
	spmf_req_if.sink  req,
	spmf_rsp_if.source rsp
);

	import spmf_pkg::*;

	localparam int AW = $clog2(LEVELS * DEPTH);

	logic          in_acc;
	logic          s1_adv;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [31:0]   ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [31:0]   ram_rdata;
	res_info_t     info;

	logic          valid_s1;
	res_info_t     info_s1;

	logic               valid_q;
	logic signed [31:0] data_q;
	status_t            status_q;
	logic [3:0]         level_q;

	// Handshake: the read stage moves on when the output register is empty or being drained.
	assign s1_adv    = valid_s1 && (!valid_q || rsp.ready);
	assign req.ready = !valid_s1 || s1_adv;
	assign in_acc    = req.valid && req.ready;

	spmf_ctrl #(
		.LEVELS (LEVELS),
		.DEPTH  (DEPTH),
		.AW     (AW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (in_acc),
		.req_type     (req.req_type),
		.value        (req.value),
		.priority_req (req.priority_req),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_re       (ram_re),
		.ram_raddr    (ram_raddr),
		.info         (info)
	);

	spmf_ram #(
		.WIDTH (32),
		.DEPTH (LEVELS * DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Read stage: holds the outcome of each accepted request and waits for the storage read data of a dequeue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			info_s1 <= info;
		end
	end

	// Output register: holds the result beat until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s1_adv) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			data_q   <= info_s1.rd ? ram_rdata : '0;
			status_q <= info_s1.status;
			level_q  <= info_s1.level;
		end
	end

	assign rsp.valid        = valid_q;
	assign rsp.data_out     = data_q;
	assign rsp.status       = status_q;
	assign rsp.served_level = level_q;

	// Checks on the result path.
	`SPMF_ASSERT_NOW(a_err_level_zero, rsp.valid && (rsp.status != ST_OK), rsp.served_level == 4'd0, "error result carries a nonzero level")
	`SPMF_ASSERT_NOW(a_empty_data_zero, rsp.valid && (rsp.status == ST_EMPTY), rsp.data_out == 32'sd0, "empty result carries nonzero data")
	`SPMF_ASSERT_NEXT(a_bad_level, in_acc && (req.req_type == REQ_ENQ) && (int'(req.priority_req) >= LEVELS), valid_s1 && (info_s1.status == ST_BAD_LEVEL), "out-of-range level not rejected")
	`SPMF_ASSERT_NOW(a_stall_holds, !req.ready, valid_s1 && valid_q && !rsp.ready, "request blocked without a stalled result")

endmodule

`default_nettype wire
